@@ sv/button_press_qualifier_unit_macros.svh @@
`ifndef BUTTON_PRESS_QUALIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_QUALIFIER_UNIT_MACROS_SVH

// Check a property on clk_i, off while reset is asserted.
`define BPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on clk_i, also while reset is asserted.
`define BPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/bpq_pkg.sv @@
package bpq_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int PIN_BITS    = 4;
  localparam int OUT_LANES   = (NUM_BUTTONS < PIN_BITS) ? NUM_BUTTONS : PIN_BITS;
  localparam int MS_W        = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd250;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic lng;
    logic rep;
    logic held;
  } lane_evt_t;

endpackage

@@ sv/bpq_lane.sv @@
module bpq_lane
  import bpq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [MS_W-1:0] now_ms_i,
  input  logic            down_i,
  input  cfg_t            cfg_i,
  output lane_evt_t       evt_o
);

  logic            held_q, held_d;
  logic            long_fired_q, long_fired_d;
  logic [MS_W-1:0] hold_start_q, hold_start_d;
  logic [MS_W-1:0] last_rep_q, last_rep_d;
  logic [MS_W-1:0] last_edge_q, last_edge_d;

  logic [MS_W-1:0] edge_age, hold_age, rep_age;
  logic            edge_ok, press, release_ok, lng, rep;

  assign edge_age = now_ms_i - last_edge_q;
  assign hold_age = now_ms_i - hold_start_q;
  assign rep_age  = now_ms_i - last_rep_q;
  assign edge_ok  = edge_age > MS_W'(cfg_i.debounce_ms);

  assign press      = down_i && !held_q && edge_ok;
  assign lng        = down_i && held_q && !long_fired_q &&
                      (hold_age > MS_W'(cfg_i.long_press_ms));
  assign rep        = down_i && held_q && long_fired_q &&
                      (rep_age > MS_W'(cfg_i.repeat_interval_ms));
  assign release_ok = !down_i && held_q && edge_ok;

  always_comb begin
    held_d       = held_q;
    long_fired_d = long_fired_q;
    hold_start_d = hold_start_q;
    last_rep_d   = last_rep_q;
    last_edge_d  = last_edge_q;
    if (press) begin
      held_d       = 1'b1;
      long_fired_d = 1'b0;
      hold_start_d = now_ms_i;
      last_rep_d   = now_ms_i;
      last_edge_d  = now_ms_i;
    end
    if (lng) begin
      long_fired_d = 1'b1;
    end
    if (rep) begin
      last_rep_d = now_ms_i;
    end
    if (release_ok) begin
      held_d      = 1'b0;
      last_edge_d = now_ms_i;
    end
  end

  assign evt_o.press = press;
  assign evt_o.lng   = lng;
  assign evt_o.rep   = rep;
  assign evt_o.held  = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 1'b0;
      long_fired_q <= 1'b0;
      hold_start_q <= '0;
      last_rep_q   <= '0;
      last_edge_q  <= '0;
    end else if (accept_i) begin
      held_q       <= held_d;
      long_fired_q <= long_fired_d;
      hold_start_q <= hold_start_d;
      last_rep_q   <= last_rep_d;
      last_edge_q  <= last_edge_d;
    end
  end

endmodule

@@ sv/bpq_merge.sv @@
module bpq_merge
  import bpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lane_evt_t           evts_i [NUM_BUTTONS],
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [PIN_BITS-1:0] press_mask_o,
  output logic [PIN_BITS-1:0] long_mask_o,
  output logic [PIN_BITS-1:0] repeat_mask_o,
  output logic [PIN_BITS-1:0] held_mask_o
);

  logic                valid_q, valid_d;
  logic [PIN_BITS-1:0] press_q, press_d;
  logic [PIN_BITS-1:0] long_q, long_d;
  logic [PIN_BITS-1:0] rep_q, rep_d;
  logic [PIN_BITS-1:0] held_q, held_d;

  always_comb begin
    press_d = '0;
    long_d  = '0;
    rep_d   = '0;
    held_d  = '0;
    for (int i = 0; i < OUT_LANES; i++) begin
      press_d[i] = evts_i[i].press;
      long_d[i]  = evts_i[i].lng;
      rep_d[i]   = evts_i[i].rep;
      held_d[i]  = evts_i[i].held;
    end
  end

  assign valid_d = accept_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      press_q <= press_d;
      long_q  <= long_d;
      rep_q   <= rep_d;
      held_q  <= held_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign press_mask_o  = press_q;
  assign long_mask_o   = long_q;
  assign repeat_mask_o = rep_q;
  assign held_mask_o   = held_q;

endmodule

@@ sv/button_press_qualifier_unit.sv @@
// Output: a result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while the output is not stalled; each button lane does its
// three wrapping 32-bit age compares combinationally, and one output register holds the masks.
// Reset: asynchronous, active low; clears all button state and timestamps to
// zero, loads debounce 50, long press 1000, repeat 250, empties the output.
`include "button_press_qualifier_unit_macros.svh"

module button_press_qualifier_unit
  import bpq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MS_W-1:0]      now_ms_i,
  input  logic [PIN_BITS-1:0]  pin_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIN_BITS-1:0]  press_mask_o,
  output logic [PIN_BITS-1:0]  long_mask_o,
  output logic [PIN_BITS-1:0]  repeat_mask_o,
  output logic [PIN_BITS-1:0]  held_mask_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t      cfg_q;
  lane_evt_t evts [NUM_BUTTONS];
  logic      accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= DEBOUNCE_RST;
      cfg_q.long_press_ms      <= LONG_PRESS_RST;
      cfg_q.repeat_interval_ms <= REPEAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:   cfg_q.debounce_ms        <= cfg_data_i;
        REG_LONG_PRESS: cfg_q.long_press_ms      <= cfg_data_i;
        REG_REPEAT:     cfg_q.repeat_interval_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic down;
    if (b < PIN_BITS) begin : g_pin
      assign down = ~pin_levels_i[b];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    bpq_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .now_ms_i (now_ms_i),
      .down_i   (down),
      .cfg_i    (cfg_q),
      .evt_o    (evts[b])
    );
  end

  bpq_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .evts_i        (evts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .press_mask_o  (press_mask_o),
    .long_mask_o   (long_mask_o),
    .repeat_mask_o (repeat_mask_o),
    .held_mask_o   (held_mask_o)
  );

  `BPQ_ASSERT(a_press_not_long, out_valid_o |-> ((press_mask_o & long_mask_o) == '0), "press and long on one button")
  `BPQ_ASSERT(a_long_not_rep, out_valid_o |-> ((long_mask_o & repeat_mask_o) == '0), "long and repeat on one button")
  `BPQ_ASSERT(a_press_held, out_valid_o |-> ((press_mask_o & ~held_mask_o) == '0), "press without held")
  `BPQ_ASSERT(a_accept_out, (in_valid_i && !in_stall_o) |=> out_valid_o, "accepted item produced no result")

endmodule
